>>> hw/rtl/tprpm_pkg.sv
// shared types and constants for the three-phase rms and power meter
package tprpm_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int SQSUM_W     = 44;
  localparam int PWSUM_W     = 45;
  localparam int RES_W       = SAMPLE_BITS + 2;
  localparam int RSQ_W       = 2 * RES_W;
  localparam int RSUM_W      = 48;
  localparam int DIV_W       = 48;
  localparam int ROOT_W      = DIV_W / 2;
  localparam int STEP_W      = 6;
  localparam int DIV_STEPS   = DIV_W;
  localparam int SQRT_STEPS  = ROOT_W;

  localparam logic [3:0] Q_FIRST     = 4'd0;
  localparam logic [3:0] Q_RMS_LAST  = 4'd8;
  localparam logic [3:0] Q_PWR_FIRST = 4'd9;
  localparam logic [3:0] Q_PWR_LAST  = 4'd11;
  localparam logic [3:0] Q_RES_FIRST = 4'd12;
  localparam logic [3:0] Q_LAST      = 4'd13;

  typedef struct packed {
    logic signed [15:0] volt_a;
    logic signed [15:0] volt_b;
    logic signed [15:0] volt_c;
    logic signed [15:0] volt_ab;
    logic signed [15:0] volt_bc;
    logic signed [15:0] volt_ca;
    logic signed [15:0] curr_a;
    logic signed [15:0] curr_b;
    logic signed [15:0] curr_c;
    logic               window_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         quantity;
    logic signed [31:0] value;
    logic               overflow;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       mul;
    logic       acc;
    logic       div_load;
    logic       div_step;
    logic       sqrt_load;
    logic       sqrt_step;
    logic       emit;
    logic       is_power;
    logic       last;
    logic [3:0] quantity;
  } ctrl_cmd_t;

  typedef struct packed {
    logic wend;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/tprpm_ctrl.sv
// sequencer for capture, multiply, accumulation, division, square root and emit steps
module tprpm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tprpm_pkg::dp_status_t  status,
  output tprpm_pkg::ctrl_cmd_t   cmd
);

  tprpm_pkg::state_t state, state_next;
  logic [3:0] k;
  logic [tprpm_pkg::STEP_W-1:0] step;
  logic is_power;

  assign is_power = (k >= tprpm_pkg::Q_PWR_FIRST) && (k <= tprpm_pkg::Q_PWR_LAST);

  always_comb begin
    state_next = state;
    unique case (state)
      tprpm_pkg::ST_IDLE: begin
        if (in_valid) state_next = tprpm_pkg::ST_MUL;
      end
      tprpm_pkg::ST_MUL: state_next = tprpm_pkg::ST_ACC;
      tprpm_pkg::ST_ACC: begin
        state_next = status.wend ? tprpm_pkg::ST_DIV_LOAD : tprpm_pkg::ST_IDLE;
      end
      tprpm_pkg::ST_DIV_LOAD: state_next = tprpm_pkg::ST_DIV;
      tprpm_pkg::ST_DIV: begin
        if (step == tprpm_pkg::STEP_W'(tprpm_pkg::DIV_STEPS - 1))
          state_next = is_power ? tprpm_pkg::ST_EMIT : tprpm_pkg::ST_SQRT_LOAD;
      end
      tprpm_pkg::ST_SQRT_LOAD: state_next = tprpm_pkg::ST_SQRT;
      tprpm_pkg::ST_SQRT: begin
        if (step == tprpm_pkg::STEP_W'(tprpm_pkg::SQRT_STEPS - 1))
          state_next = tprpm_pkg::ST_EMIT;
      end
      tprpm_pkg::ST_EMIT: begin
        if (status.out_free)
          state_next = (k == tprpm_pkg::Q_LAST) ? tprpm_pkg::ST_IDLE
                                                : tprpm_pkg::ST_DIV_LOAD;
      end
      default: state_next = tprpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.is_power  = is_power;
    cmd.last      = (k == tprpm_pkg::Q_LAST);
    cmd.quantity  = k;
    in_ready      = 1'b0;
    unique case (state)
      tprpm_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      tprpm_pkg::ST_MUL:       cmd.mul       = 1'b1;
      tprpm_pkg::ST_ACC:       cmd.acc       = 1'b1;
      tprpm_pkg::ST_DIV_LOAD:  cmd.div_load  = 1'b1;
      tprpm_pkg::ST_DIV:       cmd.div_step  = 1'b1;
      tprpm_pkg::ST_SQRT_LOAD: cmd.sqrt_load = 1'b1;
      tprpm_pkg::ST_SQRT:      cmd.sqrt_step = 1'b1;
      tprpm_pkg::ST_EMIT:      cmd.emit      = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tprpm_pkg::ST_IDLE;
      k     <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == tprpm_pkg::ST_ACC) k <= '0;
      if (cmd.emit) k <= k + 4'd1;
      if (state == tprpm_pkg::ST_DIV_LOAD || state == tprpm_pkg::ST_SQRT_LOAD)
        step <= '0;
      else if (state == tprpm_pkg::ST_DIV || state == tprpm_pkg::ST_SQRT)
        step <= step + 1'b1;
    end
  end

endmodule

>>> hw/rtl/tprpm_datapath.sv
// sample products, window sums, serial divider, serial square root, result register
module tprpm_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  tprpm_pkg::in_item_t    in_data,
  input  tprpm_pkg::ctrl_cmd_t   cmd,
  output tprpm_pkg::dp_status_t  status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tprpm_pkg::out_item_t   out_data
);

  logic signed [15:0] smp [9];
  logic               wend;

  logic [tprpm_pkg::SQ_W-1:0]          sq   [9];
  logic signed [tprpm_pkg::SQ_W-1:0]   pw   [3];
  logic [tprpm_pkg::RSQ_W-1:0]         rsq  [2];

  logic [tprpm_pkg::SQSUM_W-1:0]       sq_sum [9];
  logic signed [tprpm_pkg::PWSUM_W-1:0] pw_sum [3];
  logic [tprpm_pkg::RSUM_W-1:0]        r_sum  [2];
  logic [tprpm_pkg::CNT_W-1:0]         count;
  logic                                ovf;

  logic [tprpm_pkg::DIV_W-1:0]         div_d;
  logic [tprpm_pkg::CNT_W-1:0]         div_rem;
  logic                                div_neg;
  logic [tprpm_pkg::CNT_W:0]           rem_sh;
  logic                                qbit;

  logic [tprpm_pkg::DIV_W-1:0]         sq_op;
  logic [tprpm_pkg::ROOT_W+1:0]        sq_rem;
  logic [tprpm_pkg::ROOT_W-1:0]        sq_root;
  logic [tprpm_pkg::ROOT_W+1:0]        rem_t;
  logic [tprpm_pkg::ROOT_W+1:0]        trial;
  logic                                rbit;

  logic [tprpm_pkg::DIV_W-1:0]         operand;
  logic                                op_neg;
  logic [1:0]                          pw_idx;
  logic signed [tprpm_pkg::RES_W-1:0]  rv, ri;
  logic [tprpm_pkg::RSUM_W:0]          r_add [2];
  logic signed [31:0]                  value;

  assign status.wend     = wend;
  assign status.out_free = !out_valid || out_ready;

  assign rv = tprpm_pkg::RES_W'(smp[0]) + tprpm_pkg::RES_W'(smp[1]) + tprpm_pkg::RES_W'(smp[2]);
  assign ri = tprpm_pkg::RES_W'(smp[6]) + tprpm_pkg::RES_W'(smp[7]) + tprpm_pkg::RES_W'(smp[8]);

  assign pw_idx = 2'(cmd.quantity - tprpm_pkg::Q_PWR_FIRST);

  always_comb begin
    for (int j = 0; j < 2; j++)
      r_add[j] = {1'b0, r_sum[j]} + (tprpm_pkg::RSUM_W + 1)'(rsq[j]);
  end

  // operand for the current quantity, power as magnitude and sign
  always_comb begin
    operand = '0;
    op_neg  = 1'b0;
    unique case (cmd.quantity) inside
      [tprpm_pkg::Q_FIRST : tprpm_pkg::Q_RMS_LAST]:
        operand = tprpm_pkg::DIV_W'(sq_sum[cmd.quantity]);
      [tprpm_pkg::Q_PWR_FIRST : tprpm_pkg::Q_PWR_LAST]: begin
        op_neg  = pw_sum[pw_idx][tprpm_pkg::PWSUM_W-1];
        operand = op_neg ? tprpm_pkg::DIV_W'(-pw_sum[pw_idx])
                         : tprpm_pkg::DIV_W'(pw_sum[pw_idx]);
      end
      [tprpm_pkg::Q_RES_FIRST : tprpm_pkg::Q_LAST]: operand = r_sum[cmd.quantity[0]];
      default: ;
    endcase
  end

  assign rem_sh = {div_rem, div_d[tprpm_pkg::DIV_W-1]};
  assign qbit   = rem_sh >= {1'b0, count};

  assign rem_t = {sq_rem[tprpm_pkg::ROOT_W-1:0], sq_op[tprpm_pkg::DIV_W-1 -: 2]};
  assign trial = {sq_root, 2'b01};
  assign rbit  = rem_t >= trial;

  always_comb begin
    if (cmd.is_power)
      value = div_neg ? -$signed(div_d[31:0]) : $signed(div_d[31:0]);
    else
      value = $signed({{(32 - tprpm_pkg::ROOT_W){1'b0}}, sq_root});
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp[0] <= in_data.volt_a;
      smp[1] <= in_data.volt_b;
      smp[2] <= in_data.volt_c;
      smp[3] <= in_data.volt_ab;
      smp[4] <= in_data.volt_bc;
      smp[5] <= in_data.volt_ca;
      smp[6] <= in_data.curr_a;
      smp[7] <= in_data.curr_b;
      smp[8] <= in_data.curr_c;
      wend   <= in_data.window_end;
    end
    if (cmd.mul) begin
      for (int j = 0; j < 9; j++) sq[j] <= tprpm_pkg::SQ_W'(smp[j] * smp[j]);
      for (int j = 0; j < 3; j++) pw[j] <= smp[j] * smp[j + 6];
      rsq[0] <= tprpm_pkg::RSQ_W'(rv * rv);
      rsq[1] <= tprpm_pkg::RSQ_W'(ri * ri);
    end
    if (cmd.div_load) begin
      div_d   <= operand;
      div_neg <= op_neg;
      div_rem <= '0;
    end else if (cmd.div_step) begin
      div_d   <= {div_d[tprpm_pkg::DIV_W-2:0], qbit};
      div_rem <= qbit ? tprpm_pkg::CNT_W'(rem_sh - {1'b0, count})
                      : tprpm_pkg::CNT_W'(rem_sh);
    end
    if (cmd.sqrt_load) begin
      sq_op   <= div_d;
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sqrt_step) begin
      sq_op   <= {sq_op[tprpm_pkg::DIV_W-3:0], 2'b00};
      sq_rem  <= rbit ? rem_t - trial : rem_t;
      sq_root <= {sq_root[tprpm_pkg::ROOT_W-2:0], rbit};
    end
    if (cmd.emit) begin
      out_data.quantity    <= cmd.quantity;
      out_data.value       <= value;
      out_data.overflow    <= ovf;
      out_data.last_of_run <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.emit && cmd.last)) begin
      for (int j = 0; j < 9; j++) sq_sum[j] <= '0;
      for (int j = 0; j < 3; j++) pw_sum[j] <= '0;
      r_sum[0] <= '0;
      r_sum[1] <= '0;
      count    <= '0;
      ovf      <= 1'b0;
    end else if (cmd.acc) begin
      if (count != tprpm_pkg::CNT_W'(tprpm_pkg::MAX_SAMPLES)) begin
        for (int j = 0; j < 9; j++)
          sq_sum[j] <= sq_sum[j] + tprpm_pkg::SQSUM_W'(sq[j]);
        for (int j = 0; j < 3; j++)
          pw_sum[j] <= pw_sum[j] + tprpm_pkg::PWSUM_W'(pw[j]);
        for (int j = 0; j < 2; j++)
          r_sum[j] <= r_add[j][tprpm_pkg::RSUM_W] ? '1 : r_add[j][tprpm_pkg::RSUM_W-1:0];
        count <= count + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/three_phase_rms_power_meter_top.sv
// top level of the three-phase true rms and active power meter
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data  (tprpm_pkg::in_item_t)
//   out      output     out_valid / out_ready  out_data (tprpm_pkg::out_item_t)
//
// a sample request passes through capture, multiply and accumulate into the sums
// a window-end request then yields 14 results, each from one-bit-a-cycle division,
// then two-bit-a-cycle square root for rms results, and an emit
// synchronous active-high reset clears sums, count and control; no clearing pass
// a stalled output holds the sequencer in its emit step; in_ready drops while busy
module three_phase_rms_power_meter_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tprpm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tprpm_pkg::out_item_t out_data
);

  // command and status between sequencer and datapath
  tprpm_pkg::ctrl_cmd_t  cmd;
  tprpm_pkg::dp_status_t status;

  tprpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tprpm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sim/tb.sv
// testbench for the three-phase rms and power meter: random and directed sample windows
module tb;

  // running sums of one window and the expected results of closed windows
  class meter_scoreboard;
    longint unsigned      sq_sum[9];
    longint               pw_sum[3];
    longint unsigned      res_sum[2];
    int                   n_samples;
    bit                   dropped;
    tprpm_pkg::out_item_t pending[$];
    int                   errors;

    function void clear_window();
      foreach (sq_sum[k]) sq_sum[k] = 0;
      foreach (pw_sum[k]) pw_sum[k] = 0;
      res_sum[0] = 0;
      res_sum[1] = 0;
      n_samples = 0;
      dropped = 0;
    endfunction

    function longint unsigned floor_root(longint unsigned x);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (longint'(1) << b);
        if (t * t <= x) r = t;
      end
      return r;
    endfunction

    function void note_sample(tprpm_pkg::in_item_t it);
      longint               s[9];
      longint               rv;
      longint               ri;
      longint               v;
      tprpm_pkg::out_item_t r;
      s[0] = it.volt_a;  s[1] = it.volt_b;  s[2] = it.volt_c;
      s[3] = it.volt_ab; s[4] = it.volt_bc; s[5] = it.volt_ca;
      s[6] = it.curr_a;  s[7] = it.curr_b;  s[8] = it.curr_c;
      if (n_samples < tprpm_pkg::MAX_SAMPLES) begin
        rv = s[0] + s[1] + s[2];
        ri = s[6] + s[7] + s[8];
        for (int k = 0; k < 9; k++) sq_sum[k] += s[k] * s[k];
        for (int k = 0; k < 3; k++) pw_sum[k] += s[k] * s[6 + k];
        res_sum[0] += rv * rv;
        res_sum[1] += ri * ri;
        n_samples++;
      end else begin
        dropped = 1;
      end
      if (!it.window_end) return;
      for (int k = 0; k <= tprpm_pkg::Q_LAST; k++) begin
        if (k < tprpm_pkg::Q_PWR_FIRST) v = floor_root(sq_sum[k] / n_samples);
        else if (k <= tprpm_pkg::Q_PWR_LAST) v = pw_sum[k - tprpm_pkg::Q_PWR_FIRST] / n_samples;
        else v = floor_root(res_sum[k - tprpm_pkg::Q_RES_FIRST] / n_samples);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        r.quantity    = 4'(k);
        r.value       = 32'(v);
        r.overflow    = dropped;
        r.last_of_run = (k == tprpm_pkg::Q_LAST);
        pending = {pending, r};
      end
      clear_window();
    endfunction

    function void check_result(tprpm_pkg::out_item_t got);
      tprpm_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result q=%0d value=%0d", $time, got.quantity, got.value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.quantity !== want.quantity || got.value !== want.value ||
          got.overflow !== want.overflow || got.last_of_run !== want.last_of_run) begin
        $display("%0t: mismatch expected q=%0d v=%0d ovf=%0b last=%0b got q=%0d v=%0d ovf=%0b last=%0b",
                 $time, want.quantity, want.value, want.overflow, want.last_of_run,
                 got.quantity, got.value, got.overflow, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  tprpm_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  tprpm_pkg::out_item_t out_data;

  meter_scoreboard sb;
  int  idle_pct;     // chance of a sender gap per cycle
  int  stall_pct;    // chance of a receiver stall per cycle
  int  hold_cycles;  // long receiver hold-off, counted down by the receiver

  three_phase_rms_power_meter_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #(12 * 2000000);
    $display("FAIL");
    $finish;
  end

  // observe both channels at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_sample(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // receiver: random stalls, plus the long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (hold_cycles > 0) begin
      out_ready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one sample channel value: extremes often, otherwise anything
  function automatic logic signed [15:0] pick_code();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return $urandom_range(1) ? 16'sh0001 : 16'shffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic tprpm_pkg::in_item_t random_sample(bit wend);
    tprpm_pkg::in_item_t it;
    it.volt_a  = pick_code(); it.volt_b  = pick_code(); it.volt_c  = pick_code();
    it.volt_ab = pick_code(); it.volt_bc = pick_code(); it.volt_ca = pick_code();
    it.curr_a  = pick_code(); it.curr_b  = pick_code(); it.curr_c  = pick_code();
    it.window_end = wend;
    return it;
  endfunction

  function automatic tprpm_pkg::in_item_t flat_sample(logic signed [15:0] v,
                                                      logic signed [15:0] i, bit wend);
    tprpm_pkg::in_item_t it;
    it.volt_a = v; it.volt_b = v; it.volt_c = v;
    it.volt_ab = v; it.volt_bc = v; it.volt_ca = v;
    it.curr_a = i; it.curr_b = i; it.curr_c = i;
    it.window_end = wend;
    return it;
  endfunction

  // offer one request, hold it until taken, then maybe leave gaps
  task automatic send_sample(tprpm_pkg::in_item_t it);
    in_valid <= 1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  // a window of random samples, the last one closing it
  task automatic send_window(int len);
    for (int k = 0; k < len; k++) send_sample(random_sample(k == len - 1));
  endtask

  task automatic random_phase(int idle, int stall, int n_items);
    int sent;
    int len;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(12, 1);
      send_window(len);
      sent += len;
    end
  endtask

  initial begin
    sb = new();
    sb.clear_window();
    sb.errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: extremes, sign mixes, single-, two- and three-sample windows, then a random window
    send_sample(flat_sample(16'sh8000, 16'sh8000, 1));
    send_sample(flat_sample(16'sh7fff, 16'sh7fff, 1));
    send_sample(flat_sample(16'sh7fff, 16'sh8000, 1));
    send_sample(flat_sample(16'sh0000, 16'sh0000, 0));
    send_sample(flat_sample(16'sh0000, 16'sh0000, 1));
    send_sample(flat_sample(16'sh8000, 16'sh7fff, 0));
    send_sample(flat_sample(16'sh0001, 16'shffff, 1));
    send_sample(flat_sample(16'shffff, 16'sh0003, 0));
    send_sample(flat_sample(16'sh5555, 16'shaaaa, 0));
    send_sample(flat_sample(16'shaaaa, 16'sh5555, 1));
    send_window(6);

    random_phase(0, 0, 90);
    random_phase(82, 0, 80);
    random_phase(0, 82, 80);
    random_phase(24, 24, 80);

    // long receiver hold-off while requests keep coming, so the input stalls
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles <= 3000;
    send_window(3);
    send_window(2);
    send_window(4);

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
